// ===== rtl/core/lslf_pkg.sv =====
// lslf_pkg: widths, operation codes and command/status types of the line fitter
// shared by lslf_ctrl, lslf_dp and lslf_div; depends on nothing
package lslf_pkg;

    // point limit and field widths
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = 11;
    localparam int XY_W       = 16;
    localparam int PROD_W     = 2 * XY_W;
    localparam int SUM_W      = 27;
    localparam int SQ_W       = 43;
    localparam int RES_W      = 32;

    // fit arithmetic: accumulator, stored terms, divider operands
    localparam int ACC_W      = SQ_W + SUM_W;
    localparam int DEN_W      = 52;
    localparam int SNUM_W     = 53;
    localparam int INUM_W     = 68;
    localparam int SLOPE_SH   = 16;
    localparam int ICPT_SH    = 8;
    localparam int DNUM_W     = INUM_W + ICPT_SH;
    localparam int STEP_W     = $clog2(DNUM_W);

    // stream packing
    localparam int IN_DATA_W  = 2 * XY_W;
    localparam int OUT_DATA_W = ((2 * RES_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // products formed by the shared multiplier, odd codes close a term
    typedef enum logic [2:0] {
        P_N_SXX  = 3'd0,
        P_SX_SX  = 3'd1,
        P_N_SXY  = 3'd2,
        P_SX_SY  = 3'd3,
        P_SXX_SY = 3'd4,
        P_SX_SXY = 3'd5
    } mul_sel_t;

    // divisions: mean of y, slope, intercept
    typedef enum logic [1:0] {
        D_MEAN_Y = 2'd0,
        D_SLOPE  = 2'd1,
        D_ICPT   = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     acc_en;
        logic     fit_start;
        logic     mul_load;
        logic     mul_step;
        logic     mul_last;
        logic     store_en;
        mul_sel_t mul_sel;
        logic     div_load;
        logic     div_step;
        logic     div_finish;
        div_sel_t div_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic degen;
    } dp_status_t;

endpackage

// ===== rtl/core/lslf_div.sv =====
// lslf_div: restoring divider, one quotient bit per cycle while step is high, rounding and 32-bit clipping
// depends on lslf_pkg
module lslf_div (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        step,
    input  logic [lslf_pkg::DNUM_W-1:0] num,
    input  logic [lslf_pkg::DEN_W-1:0]  den,
    output logic [lslf_pkg::RES_W-1:0]  quo,
    output logic                        ovf
);
    import lslf_pkg::*;

    logic [DNUM_W-1:0] nm_reg, nm_next;
    logic [DNUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0]  r_reg, r_next;
    logic [DEN_W-1:0]  d_reg;
    logic              neg_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              rnd;
    logic [DNUM_W:0]   q_rnd;
    logic [DNUM_W:0]   lim;
    logic [RES_W-1:0]  mag;

    // one shift-and-subtract step
    always_comb
    begin
        trial   = {r_reg, nm_reg[DNUM_W-1]};
        diff    = trial - {1'b0, d_reg};
        nm_next = {nm_reg[DNUM_W-2:0], 1'b0};
        if (trial >= {1'b0, d_reg})
        begin
            r_next = diff[DEN_W-1:0];
            q_next = {q_reg[DNUM_W-2:0], 1'b1};
        end
        else
        begin
            r_next = trial[DEN_W-1:0];
            q_next = {q_reg[DNUM_W-2:0], 1'b0};
        end
    end

    // operand capture and iteration
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= num[DNUM_W-1];
            nm_reg  <= num[DNUM_W-1] ? (~num + 1'b1) : num;
            q_reg   <= '0;
            r_reg   <= '0;
            d_reg   <= den;
        end
        else if (step)
        begin
            nm_reg <= nm_next;
            q_reg  <= q_next;
            r_reg  <= r_next;
        end
    end

    // round half away from zero, then clip to the signed 32-bit range
    always_comb
    begin
        rnd   = ({r_reg, 1'b0} >= {1'b0, d_reg});
        q_rnd = {1'b0, q_reg} + {{DNUM_W{1'b0}}, rnd};
        lim   = neg_reg ? ((DNUM_W+1)'(1) << (RES_W - 1))
                        : (((DNUM_W+1)'(1) << (RES_W - 1)) - 1'b1);
        ovf   = (q_rnd > lim);
        mag   = ovf ? lim[RES_W-1:0] : q_rnd[RES_W-1:0];
        quo   = neg_reg ? (~mag + 1'b1) : mag;
    end

endmodule

// ===== rtl/core/lslf_dp.sv =====
// lslf_dp: running sums, bit-serial multiply-accumulate, fit terms and result registers
// depends on lslf_pkg and lslf_div
module lslf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lslf_pkg::dp_cmd_t              cmd,
    output lslf_pkg::dp_status_t           status,
    input  logic [lslf_pkg::IN_DATA_W-1:0] in_data,
    output logic [lslf_pkg::RES_W-1:0]     out_slope,
    output logic [lslf_pkg::RES_W-1:0]     out_intercept,
    output logic                           out_degenerate,
    output logic                           out_saturated,
    output logic [lslf_pkg::CNT_W-1:0]     out_total
);
    import lslf_pkg::*;

    logic signed [XY_W-1:0]   x_in, y_in;
    logic signed [PROD_W-1:0] xx_prod, xy_prod;

    logic [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [SQ_W-1:0]  sum_xx_reg, sum_xy_reg;
    logic [CNT_W-1:0] count_reg;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] mpa_reg, mpa_sel;
    logic [SUM_W-1:0] mpb_reg, mpb_sel;
    logic             msub_reg;

    logic [DEN_W-1:0]  den_reg;
    logic [SNUM_W-1:0] snum_reg;
    logic [INUM_W-1:0] inum_reg;
    logic              degen_reg;
    logic              sat_reg;
    logic [RES_W-1:0]  slope_res_reg, icpt_res_reg;

    logic [DNUM_W-1:0] div_num;
    logic [DEN_W-1:0]  div_den;
    logic [RES_W-1:0]  div_quo;
    logic              div_ovf;

    assign x_in    = in_data[XY_W-1:0];
    assign y_in    = in_data[IN_DATA_W-1:XY_W];
    assign xx_prod = x_in * x_in;
    assign xy_prod = x_in * y_in;

    // running sums, points beyond the limit are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.out_load)
        begin
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.acc_en && (count_reg < CNT_W'(MAX_POINTS)))
        begin
            sum_x_reg  <= sum_x_reg + {{(SUM_W-XY_W){x_in[XY_W-1]}}, x_in};
            sum_y_reg  <= sum_y_reg + {{(SUM_W-XY_W){y_in[XY_W-1]}}, y_in};
            sum_xx_reg <= sum_xx_reg + {{(SQ_W-PROD_W){xx_prod[PROD_W-1]}}, xx_prod};
            sum_xy_reg <= sum_xy_reg + {{(SQ_W-PROD_W){xy_prod[PROD_W-1]}}, xy_prod};
            count_reg  <= count_reg + 1'b1;
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            P_N_SXX:
            begin
                mpa_sel = {{(ACC_W-SQ_W){sum_xx_reg[SQ_W-1]}}, sum_xx_reg};
                mpb_sel = {{(SUM_W-CNT_W){1'b0}}, count_reg};
            end
            P_SX_SX:
            begin
                mpa_sel = {{(ACC_W-SUM_W){sum_x_reg[SUM_W-1]}}, sum_x_reg};
                mpb_sel = sum_x_reg;
            end
            P_N_SXY:
            begin
                mpa_sel = {{(ACC_W-SQ_W){sum_xy_reg[SQ_W-1]}}, sum_xy_reg};
                mpb_sel = {{(SUM_W-CNT_W){1'b0}}, count_reg};
            end
            P_SX_SY:
            begin
                mpa_sel = {{(ACC_W-SUM_W){sum_x_reg[SUM_W-1]}}, sum_x_reg};
                mpb_sel = sum_y_reg;
            end
            P_SXX_SY:
            begin
                mpa_sel = {{(ACC_W-SQ_W){sum_xx_reg[SQ_W-1]}}, sum_xx_reg};
                mpb_sel = sum_y_reg;
            end
            P_SX_SXY:
            begin
                mpa_sel = {{(ACC_W-SQ_W){sum_xy_reg[SQ_W-1]}}, sum_xy_reg};
                mpb_sel = sum_x_reg;
            end
            default:
            begin
                mpa_sel = '0;
                mpb_sel = '0;
            end
        endcase
    end

    // shift-add step, the sign bit of the serial operand weighs negative
    always_comb
    begin
        acc_next = acc_reg;
        if (mpb_reg[0])
        begin
            if (msub_reg ^ cmd.mul_last)
                acc_next = acc_reg - mpa_reg;
            else
                acc_next = acc_reg + mpa_reg;
        end
    end

    // multiply-accumulate registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mpa_reg  <= mpa_sel;
            mpb_reg  <= mpb_sel;
            msub_reg <= cmd.mul_sel[0];
            if (!cmd.mul_sel[0])
                acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
            mpa_reg <= {mpa_reg[ACC_W-2:0], 1'b0};
            mpb_reg <= {mpb_reg[SUM_W-1], mpb_reg[SUM_W-1:1]};
        end
    end

    // fit terms taken from the accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.store_en)
        begin
            case (cmd.mul_sel)
                P_SX_SX:  den_reg  <= acc_reg[DEN_W-1:0];
                P_SX_SY:  snum_reg <= acc_reg[SNUM_W-1:0];
                P_SX_SXY: inum_reg <= acc_reg[INUM_W-1:0];
                default:  ;
            endcase
        end
    end

    // flags of the fit in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.store_en && (cmd.mul_sel == P_SX_SX))
                degen_reg <= acc_reg[ACC_W-1] || (acc_reg == '0);
            if (cmd.fit_start)
                sat_reg <= 1'b0;
            else if (cmd.div_finish)
                sat_reg <= sat_reg | div_ovf;
        end
    end

    assign status.degen = degen_reg;

    // dividend and divisor for the selected division
    always_comb
    begin
        case (cmd.div_sel)
            D_MEAN_Y:
            begin
                div_num = {{(DNUM_W-SUM_W-ICPT_SH){sum_y_reg[SUM_W-1]}}, sum_y_reg,
                           {ICPT_SH{1'b0}}};
                div_den = {{(DEN_W-CNT_W){1'b0}}, count_reg};
            end
            D_SLOPE:
            begin
                div_num = {{(DNUM_W-SNUM_W-SLOPE_SH){snum_reg[SNUM_W-1]}}, snum_reg,
                           {SLOPE_SH{1'b0}}};
                div_den = den_reg;
            end
            D_ICPT:
            begin
                div_num = {inum_reg, {ICPT_SH{1'b0}}};
                div_den = den_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    lslf_div u_div (
        .clk  (clk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (div_num),
        .den  (div_den),
        .quo  (div_quo),
        .ovf  (div_ovf)
    );

    // slope and intercept of the fit in progress
    always_ff @(posedge clk)
    begin
        if (cmd.fit_start)
            slope_res_reg <= '0;
        else if (cmd.div_finish && (cmd.div_sel == D_SLOPE))
            slope_res_reg <= div_quo;
        if (cmd.div_finish && (cmd.div_sel != D_SLOPE))
            icpt_res_reg <= div_quo;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_slope      <= slope_res_reg;
            out_intercept  <= icpt_res_reg;
            out_degenerate <= degen_reg;
            out_saturated  <= sat_reg;
            out_total      <= count_reg;
        end
    end

endmodule

// ===== rtl/core/lslf_ctrl.sv =====
// lslf_ctrl: sequencer for point intake, the six products, the divisions and the output request
// depends on lslf_pkg
module lslf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  lslf_pkg::dp_status_t status,
    output lslf_pkg::dp_cmd_t    cmd
);
    import lslf_pkg::*;

    typedef enum logic [2:0] {
        S_ACC,
        S_MLOAD,
        S_MSTEP,
        S_MSTORE,
        S_DLOAD,
        S_DSTEP,
        S_DDONE,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] cnt_reg;
    mul_sel_t          msel_reg;
    div_sel_t          dsel_reg;
    logic              out_valid_reg;

    logic mul_done;
    logic div_done;
    logic out_free;

    assign mul_done = (cnt_reg == STEP_W'(SUM_W - 1));
    assign div_done = (cnt_reg == STEP_W'(DNUM_W - 1));
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_ACC);
    assign out_valid = out_valid_reg;

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = msel_reg;
        cmd.div_sel = dsel_reg;
        unique case (state_reg)
            S_ACC:    cmd.acc_en = in_valid;
            S_MLOAD:
            begin
                cmd.mul_load  = 1'b1;
                cmd.fit_start = (msel_reg == P_N_SXX);
            end
            S_MSTEP:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_last = mul_done;
            end
            S_MSTORE: cmd.store_en   = 1'b1;
            S_DLOAD:  cmd.div_load   = 1'b1;
            S_DSTEP:  cmd.div_step   = 1'b1;
            S_DDONE:  cmd.div_finish = 1'b1;
            S_OUT:    cmd.out_load   = out_free;
            default:  ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            cnt_reg       <= '0;
            msel_reg      <= P_N_SXX;
            dsel_reg      <= D_MEAN_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result request raised on load, dropped once taken
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_ACC:
                begin
                    if (in_valid && in_last)
                    begin
                        msel_reg  <= P_N_SXX;
                        state_reg <= S_MLOAD;
                    end
                end
                S_MLOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MSTEP;
                end
                S_MSTEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (mul_done)
                    begin
                        if (msel_reg[0])
                            state_reg <= S_MSTORE;
                        else
                        begin
                            msel_reg  <= mul_sel_t'(msel_reg + 3'd1);
                            state_reg <= S_MLOAD;
                        end
                    end
                end
                S_MSTORE:
                begin
                    if (msel_reg == P_SX_SXY)
                    begin
                        dsel_reg  <= status.degen ? D_MEAN_Y : D_SLOPE;
                        state_reg <= S_DLOAD;
                    end
                    else
                    begin
                        msel_reg  <= mul_sel_t'(msel_reg + 3'd1);
                        state_reg <= S_MLOAD;
                    end
                end
                S_DLOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DSTEP;
                end
                S_DSTEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_done)
                        state_reg <= S_DDONE;
                end
                S_DDONE:
                begin
                    if (dsel_reg == D_SLOPE)
                    begin
                        dsel_reg  <= D_ICPT;
                        state_reg <= S_DLOAD;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_ACC;
                end
                default:  state_reg <= S_ACC;
            endcase
        end
    end

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while occupied");

    // intake stops for the fit after the last point
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("point accepted during a fit");

    // only the closing product of a term is stored
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_en |-> msel_reg[0])
        else $error("store after an opening product");

    // mean of y is only divided out for a degenerate set
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DLOAD && dsel_reg == D_MEAN_Y) |-> status.degen)
        else $error("mean path taken for a regular fit");

endmodule

// ===== rtl/core/least_squares_line_fit.sv =====
// least_squares_line_fit: top level of the least-squares straight-line fitter
// depends on lslf_pkg, lslf_ctrl, lslf_dp (with lslf_div)
//
//  channel   dir  width  contents
//  s_axis    in   32+1   tdata x_value[15:0] y_value[31:16], tlast last_point
//  m_axis    out  80+2   tdata slope intercept point_total, tuser degenerate saturated
//
// points are taken back to back; after the last point the fit runs six products on the
// bit-serial multiplier, three stores, then one division for a degenerate set or two
// otherwise, one bit per cycle
// reset clears the sums, the count and the sequencer; no points are taken during a fit
// a result waiting on m_axis does not stop intake of the next set
module least_squares_line_fit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_value[15:0], y_value[31:16]
    input  logic [lslf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slope[31:0], intercept[63:32], point_total[74:64], zero fill above
    output logic [lslf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // degenerate[0], saturated[1]
    output logic [lslf_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import lslf_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [RES_W-1:0] slope;
    logic [RES_W-1:0] intercept;
    logic             degenerate;
    logic             saturated;
    logic [CNT_W-1:0] point_total;

    // sequencer
    lslf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .status    (status),
        .cmd       (cmd)
    );

    // sums, arithmetic and result register
    lslf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_data        (s_axis_tdata),
        .out_slope      (slope),
        .out_intercept  (intercept),
        .out_degenerate (degenerate),
        .out_saturated  (saturated),
        .out_total      (point_total)
    );

    // result packing
    assign m_axis_tdata = {{(OUT_DATA_W-2*RES_W-CNT_W){1'b0}}, point_total, intercept, slope};
    assign m_axis_tuser = {saturated, degenerate};

endmodule
